// File: design/tkdl_pkg.sv
// Shared types and constants for the two-key debounce and lockout block.
// Used by tkdl_key and two_key_debounce_lockout_core; depends on nothing.
`default_nettype none

package tkdl_pkg;

  // Widths fixed by the register map and the result field.
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned EVENT_W = 2;

  // Register indexes.
  localparam logic [INDEX_W-1:0] CFG_DEBOUNCE = 8'd0;
  localparam logic [INDEX_W-1:0] CFG_HOLD     = 8'd1;

  // Register reset values.
  localparam logic [LIMIT_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [LIMIT_W-1:0] HOLD_RESET     = 16'd1000;

  // Press event codes.
  localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EVENT_W-1:0] EV_KEY_A = 2'd1;
  localparam logic [EVENT_W-1:0] EV_KEY_B = 2'd2;

  // Per-key control for one tick.
  typedef struct packed {
    logic active;    // the key is handled on this tick
    logic released;  // pin level reads released
  } key_ctl_t;

  // Per-key status seen by the top level.
  typedef struct packed {
    logic press;     // press reported on this tick
    logic locked;
    logic pressing;
  } key_stat_t;

endpackage

`default_nettype wire

// File: design/tkdl_key.sv
// Debounce, hold timeout and lock state for one key, updated once per tick.
// Depends on tkdl_pkg for the control and status structs.
`default_nettype none

module tkdl_key #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire tkdl_pkg::key_ctl_t             ctl,
  input  wire logic                           lock_set,
  input  wire logic [tkdl_pkg::LIMIT_W-1:0]   debounce_limit,
  input  wire logic [tkdl_pkg::LIMIT_W-1:0]   hold_limit,
  output tkdl_pkg::key_stat_t                 stat
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > tkdl_pkg::LIMIT_W) ? COUNT_WIDTH : tkdl_pkg::LIMIT_W;

  logic [COUNT_WIDTH-1:0] debounce_counter, debounce_counter_next;
  logic [COUNT_WIDTH-1:0] hold_counter, hold_counter_next;
  logic                   pressing, pressing_next;
  logic                   locked, locked_next;

  logic [COUNT_WIDTH-1:0] deb_inc, hold_inc;
  logic                   deb_fire, hold_fire;
  logic                   press;

  // A counting step fires when the wrapped increment reaches the limit.
  assign deb_inc   = debounce_counter + COUNT_WIDTH'(1);
  assign hold_inc  = hold_counter + COUNT_WIDTH'(1);
  assign deb_fire  = CMP_W'(deb_inc) >= CMP_W'(debounce_limit);
  assign hold_fire = CMP_W'(hold_inc) >= CMP_W'(hold_limit);

  always_comb begin
    debounce_counter_next = debounce_counter;
    hold_counter_next     = hold_counter;
    pressing_next         = pressing;
    locked_next           = locked;
    press                 = 1'b0;
    if (ctl.active) begin
      if (locked) begin
        // A locked key only waits for its pin to read released.
        if (ctl.released) begin
          locked_next = 1'b0;
        end
      end else if (!ctl.released) begin
        if (pressing) begin
          debounce_counter_next = '0;
          if (hold_fire) begin
            hold_counter_next = '0;
            locked_next       = 1'b1;
          end else begin
            hold_counter_next = hold_inc;
          end
        end else if (deb_fire) begin
          debounce_counter_next = '0;
          pressing_next         = 1'b1;
          press                 = 1'b1;
        end else begin
          debounce_counter_next = deb_inc;
        end
      end else begin
        if (pressing) begin
          if (deb_fire) begin
            debounce_counter_next = '0;
            pressing_next         = 1'b0;
          end else begin
            debounce_counter_next = deb_inc;
          end
        end else begin
          debounce_counter_next = '0;
          hold_counter_next     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_counter <= '0;
      hold_counter     <= '0;
      pressing         <= 1'b0;
      locked           <= 1'b0;
    end else begin
      debounce_counter <= debounce_counter_next;
      hold_counter     <= hold_counter_next;
      pressing         <= pressing_next;
      // A press by the other key sets the lock, which wins over any release seen here.
      locked           <= locked_next || lock_set;
    end
  end

  assign stat.press    = press;
  assign stat.locked   = locked;
  assign stat.pressing = pressing;

endmodule

`default_nettype wire

// File: design/two_key_debounce_lockout_core.sv
// Top level of the two-key debouncer with cross lockout and stuck-key timeout.
// Depends on tkdl_pkg and instantiates tkdl_key for key A and key B.
// Each tick is held in an input register, and its press event in a result register.
// Throughput: one item per cycle; the input stalls only while a result waits for out_ready.
// Synchronous active-high reset clears all counters, flags and valids and
// restores debounce_count to 20 and hold_timeout_count to 1000.
`default_nettype none

module two_key_debounce_lockout_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           key_a_level,
  input  wire logic                           key_b_level,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [tkdl_pkg::EVENT_W-1:0]        press_event,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tkdl_pkg::INDEX_W-1:0]   cfg_index,
  input  wire logic [tkdl_pkg::LIMIT_W-1:0]   cfg_data
);

  logic [tkdl_pkg::LIMIT_W-1:0] debounce_count;
  logic [tkdl_pkg::LIMIT_W-1:0] hold_timeout_count;

  logic               tick_valid;
  logic               tick_a_level;
  logic               tick_b_level;
  logic               advance;

  tkdl_pkg::key_ctl_t  ctl_a, ctl_b;
  tkdl_pkg::key_stat_t stat_a, stat_b;
  logic                lock_a, lock_b;
  logic [tkdl_pkg::EVENT_W-1:0] event_code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count     <= tkdl_pkg::DEBOUNCE_RESET;
      hold_timeout_count <= tkdl_pkg::HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tkdl_pkg::CFG_DEBOUNCE: debounce_count     <= cfg_data;
        tkdl_pkg::CFG_HOLD:     hold_timeout_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // The tick in the input register is processed when the result register is free.
  assign advance  = tick_valid && (!out_valid || out_ready);
  assign in_ready = !tick_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_ready) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick_a_level <= key_a_level;
      tick_b_level <= key_b_level;
    end
  end

  // Key B is not handled on a tick where key A reports a press.
  assign ctl_a.active   = advance;
  assign ctl_a.released = tick_a_level;
  assign ctl_b.active   = advance && !stat_a.press;
  assign ctl_b.released = tick_b_level;
  assign lock_a         = advance && stat_b.press;
  assign lock_b         = advance && stat_a.press;

  tkdl_key #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_key_a (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl_a),
    .lock_set       (lock_a),
    .debounce_limit (debounce_count),
    .hold_limit     (hold_timeout_count),
    .stat           (stat_a)
  );

  tkdl_key #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_key_b (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl_b),
    .lock_set       (lock_b),
    .debounce_limit (debounce_count),
    .hold_limit     (hold_timeout_count),
    .stat           (stat_b)
  );

  always_comb begin
    if (stat_a.press) begin
      event_code = tkdl_pkg::EV_KEY_A;
    end else if (stat_b.press) begin
      event_code = tkdl_pkg::EV_KEY_B;
    end else begin
      event_code = tkdl_pkg::EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      press_event <= event_code;
    end
  end

  a_event_code_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (press_event == tkdl_pkg::EV_NONE || press_event == tkdl_pkg::EV_KEY_A ||
                   press_event == tkdl_pkg::EV_KEY_B))
    else $error("press event code out of range");

  a_ready_when_output_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the result register is free");

  a_press_a_locks_b: assert property (@(posedge clk) disable iff (rst)
    (advance && stat_a.press) |=> (stat_b.locked && stat_a.pressing))
    else $error("key A press did not lock key B");

  a_press_b_locks_a: assert property (@(posedge clk) disable iff (rst)
    (advance && stat_b.press) |=> (stat_a.locked && stat_b.pressing))
    else $error("key B press did not lock key A");

  a_single_press: assert property (@(posedge clk) disable iff (rst)
    !(stat_a.press && stat_b.press))
    else $error("both keys reported a press on one tick");

endmodule

`default_nettype wire
